// ----- design/llct_pkg.sv -----
`default_nettype none

package llct_pkg;

    localparam int AMT_W = 32;
    localparam int POS_W = 7;
    localparam int VAL_W = 31;
    localparam int CFG_W = 7;

    typedef enum logic [1:0] {
        FUNC_ADD    = 2'd0,
        FUNC_APPEND = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_READ   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_SEARCH,
        S_ADD,
        S_SHIFT,
        S_TAIL,
        S_READ,
        S_READ_WAIT,
        S_OUT
    } t_state;

endpackage

`default_nettype wire

// ----- design/llct_ram.sv -----
`default_nettype none

module llct_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6,
    parameter int DW    = 31
) (
    input  wire logic          i_clk,
    input  wire logic          i_we,
    input  wire logic [AW-1:0] i_waddr,
    input  wire logic [DW-1:0] i_wdata,
    input  wire logic [AW-1:0] i_raddr,
    output logic      [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, old data on same-address collision
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- design/least_loaded_column_table.sv -----
`default_nettype none

// channel  | direction | handshake                  | payload
// ---------+-----------+----------------------------+----------------------------------------
// in       | to block  | i_in_valid / o_in_stall    | i_func, i_amount, i_position
// out      | from blk  | o_out_valid / i_out_stall  | o_status, o_column_index,
//          |           |                            | o_column_value, o_column_total
// cfg      | to block  | i_cfg_we                   | i_cfg_data (initial column count)
//
// one item at a time; the single read port of the column memory walks one entry a cycle
// add: minimum search over all columns, then write-back
// remove: gap closing behind the removed column, one move per cycle
// append and ignored items are settled when taken, read issues one memory read; every
// item may also wait on the out stall. after reset and after each cfg write a clearing
// pass zeroes the memory; o_in_stall stays high meanwhile, cfg writes are still taken
// a finished result sits in the output register; the next item is taken while it waits

module least_loaded_column_table #(
    parameter int MAX_COLUMNS = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // configuration
    input  wire logic                                i_cfg_we,
    input  wire logic        [llct_pkg::CFG_W-1:0]   i_cfg_data,
    // input channel
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic        [1:0]                   i_func,
    input  wire logic signed [llct_pkg::AMT_W-1:0]   i_amount,
    input  wire logic        [llct_pkg::POS_W-1:0]   i_position,
    // output channel
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic             [1:0]                   o_status,
    output logic             [llct_pkg::POS_W-1:0]   o_column_index,
    output logic             [llct_pkg::VAL_W-1:0]   o_column_value,
    output logic             [llct_pkg::POS_W-1:0]   o_column_total
);

    import llct_pkg::*;

    // memory address width and column count width (count reaches MAX_COLUMNS)
    localparam int AW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    // common width for comparing counts against 7-bit positions and cfg data
    localparam int XW = (CW > POS_W) ? CW : POS_W;

    // sequencer state
    t_state          r_state, n_state;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_src,   n_src;     // walk pointer (clear, search, shift)
    logic [AW-1:0]   r_best,  n_best;    // first column holding the minimum
    logic [VAL_W-1:0] r_min,  n_min;
    logic [VAL_W-1:0] r_amt,  n_amt;     // positive add amount
    logic [POS_W-1:0] r_pos,  n_pos;
    logic            r_rd_ok, n_rd_ok;   // r_rdata holds a walk read
    logic [AW-1:0]   r_rd_addr, n_rd_addr;

    // pending result
    t_status          r_res_status, n_res_status;
    logic [POS_W-1:0] r_res_index,  n_res_index;
    logic [VAL_W-1:0] r_res_value,  n_res_value;

    // output register
    logic             r_o_valid, n_o_valid;
    t_status          r_o_status, n_o_status;
    logic [POS_W-1:0] r_o_index,  n_o_index;
    logic [VAL_W-1:0] r_o_value,  n_o_value;
    logic [POS_W-1:0] r_o_total,  n_o_total;

    // memory port
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [VAL_W-1:0] mem_wdata;
    logic [AW-1:0]    mem_raddr;
    logic [VAL_W-1:0] mem_rdata;

    logic             in_xfer;
    logic             pos_ok;
    logic [AMT_W-1:0] add_sum;
    logic [VAL_W-1:0] add_sat;
    logic [CW-1:0]    cfg_cols;

    llct_ram #(
        .DEPTH (MAX_COLUMNS),
        .AW    (AW),
        .DW    (VAL_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_xfer    = i_in_valid && !o_in_stall;

    // position is 1-based and must name an existing column
    assign pos_ok = (i_position != '0) && (XW'(i_position) <= XW'(r_count));

    // both operands below 2^31, so the 32-bit sum cannot wrap
    assign add_sum = {1'b0, r_min} + {1'b0, r_amt};
    assign add_sat = add_sum[AMT_W-1] ? {VAL_W{1'b1}} : add_sum[VAL_W-1:0];

    // rebuild size: zero means one column, clamp at capacity
    always_comb begin
        if (i_cfg_data == '0) begin
            cfg_cols = CW'(1);
        end else if (XW'(i_cfg_data) > XW'(MAX_COLUMNS)) begin
            cfg_cols = CW'(MAX_COLUMNS);
        end else begin
            cfg_cols = CW'(i_cfg_data);
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_src        = r_src;
        n_best       = r_best;
        n_min        = r_min;
        n_amt        = r_amt;
        n_pos        = r_pos;
        n_rd_ok      = 1'b0;
        n_res_status = r_res_status;
        n_res_index  = r_res_index;
        n_res_value  = r_res_value;
        n_o_valid    = r_o_valid && i_out_stall;
        n_o_status   = r_o_status;
        n_o_index    = r_o_index;
        n_o_value    = r_o_value;
        n_o_total    = r_o_total;
        mem_we       = 1'b0;
        mem_waddr    = r_src[AW-1:0];
        mem_wdata    = '0;
        mem_raddr    = r_src[AW-1:0];

        unique case (r_state)
            S_CLEAR: begin
                mem_we = 1'b1;
                n_src  = r_src + CW'(1);
                if (r_src == CW'(MAX_COLUMNS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_xfer) begin
                    // default: ignored, nothing touched
                    n_res_status = STAT_IGNORED;
                    n_res_index  = '0;
                    n_res_value  = '0;
                    n_state      = S_OUT;
                    unique case (i_func)
                        FUNC_ADD: begin
                            if (!i_amount[AMT_W-1] && i_amount != '0 && r_count != '0) begin
                                n_amt   = i_amount[VAL_W-1:0];
                                n_src   = '0;
                                n_state = S_SEARCH;
                            end
                        end
                        FUNC_APPEND: begin
                            if (r_count == CW'(MAX_COLUMNS)) begin
                                n_res_status = STAT_FULL;
                            end else begin
                                mem_we       = 1'b1;
                                mem_waddr    = r_count[AW-1:0];
                                mem_wdata    = i_amount[AMT_W-1] ? '0 : i_amount[VAL_W-1:0];
                                n_count      = r_count + CW'(1);
                                n_res_status = STAT_DONE;
                                n_res_index  = POS_W'(r_count + CW'(1));
                                n_res_value  = mem_wdata;
                            end
                        end
                        FUNC_REMOVE: begin
                            if (pos_ok) begin
                                n_pos   = i_position;
                                n_src   = CW'(i_position);   // first column to move down
                                n_state = S_SHIFT;
                            end
                        end
                        FUNC_READ: begin
                            if (pos_ok) begin
                                n_pos   = i_position;
                                n_state = S_READ;
                            end
                        end
                    endcase
                end
            end

            // one read issued and one compare done per cycle
            S_SEARCH: begin
                if (r_rd_ok && (r_rd_addr == '0 || mem_rdata < r_min)) begin
                    n_min  = mem_rdata;
                    n_best = r_rd_addr;
                end
                if (r_src < r_count) begin
                    n_rd_ok = 1'b1;
                    n_src   = r_src + CW'(1);
                end else begin
                    n_state = S_ADD;
                end
            end

            S_ADD: begin
                mem_we       = 1'b1;
                mem_waddr    = r_best;
                mem_wdata    = add_sat;
                n_res_status = STAT_DONE;
                n_res_index  = POS_W'(XW'(r_best) + XW'(1));
                n_res_value  = add_sat;
                n_state      = S_OUT;
            end

            // column read last cycle moves one place down
            S_SHIFT: begin
                if (r_rd_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_rd_addr - AW'(1);
                    mem_wdata = mem_rdata;
                end
                if (r_src < r_count) begin
                    n_rd_ok = 1'b1;
                    n_src   = r_src + CW'(1);
                end else begin
                    n_state = S_TAIL;
                end
            end

            S_TAIL: begin
                mem_we       = 1'b1;
                mem_waddr    = AW'(r_count - CW'(1));
                mem_wdata    = '0;
                n_count      = r_count - CW'(1);
                n_res_status = STAT_DONE;
                n_res_index  = r_pos;
                n_res_value  = '0;
                n_state      = S_OUT;
            end

            S_READ: begin
                mem_raddr = AW'(r_pos - POS_W'(1));
                n_state   = S_READ_WAIT;
            end

            S_READ_WAIT: begin
                n_res_status = STAT_DONE;
                n_res_index  = r_pos;
                n_res_value  = mem_rdata;
                n_state      = S_OUT;
            end

            // hand the result over once the output register is free
            S_OUT: begin
                if (!r_o_valid || !i_out_stall) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_index  = r_res_index;
                    n_o_value  = r_res_value;
                    n_o_total  = POS_W'(r_count);
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // register write rebuilds the table and restarts the clearing pass
        if (i_cfg_we) begin
            n_count = cfg_cols;
            n_src   = '0;
            n_state = S_CLEAR;
        end
    end

    assign n_rd_addr = mem_raddr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= CW'(1);
            r_src     <= '0;
            r_rd_ok   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_count   <= n_count;
            r_src     <= n_src;
            r_rd_ok   <= n_rd_ok;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_best       <= n_best;
        r_min        <= n_min;
        r_amt        <= n_amt;
        r_pos        <= n_pos;
        r_rd_addr    <= n_rd_addr;
        r_res_status <= n_res_status;
        r_res_index  <= n_res_index;
        r_res_value  <= n_res_value;
        r_o_status   <= n_o_status;
        r_o_index    <= n_o_index;
        r_o_value    <= n_o_value;
        r_o_total    <= n_o_total;
    end

    assign o_out_valid    = r_o_valid;
    assign o_status       = r_o_status;
    assign o_column_index = r_o_index;
    assign o_column_value = r_o_value;
    assign o_column_total = r_o_total;

    // column count stays within capacity
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_count) <= XW'(MAX_COLUMNS))
        else $error("column count above capacity");

    // a non-full append grows the table by exactly one
    a_append_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_xfer && i_func == FUNC_APPEND && r_count != CW'(MAX_COLUMNS) && !i_cfg_we)
        |=> (r_count == $past(r_count) + CW'(1)))
        else $error("append did not grow the table");

    // the chosen minimum column always lies inside the table
    a_best_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADD) |-> (XW'(r_best) < XW'(r_count)))
        else $error("minimum column outside the table");

    // a cfg write always starts a clearing pass from the first entry
    a_cfg_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_we |=> (r_state == S_CLEAR && r_src == '0))
        else $error("cfg write did not restart clearing");

    // remove never ends with a walk read still pending
    a_shift_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TAIL) |-> !r_rd_ok)
        else $error("shift left a pending move");

endmodule

`default_nettype wire
